### design/t3oss_pkg.sv
// Package with the constants, codes and weight tables of the T3 orbit spin summation block.
`timescale 1ns / 1ps

package t3oss_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 48;
    localparam int FRAC_BITS = 40;
    localparam int NUM_MEMBERS = 6;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_LSB = 3;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_ALPHA = 2'd1;
    localparam logic [1:0] REG_BETA = 2'd2;

    localparam logic [1:0] MODE_FULL = 2'd0;
    localparam logic [1:0] MODE_PASS = 2'd3;

    localparam logic [63:0] ALPHA_RESET = 64'h0000_0100_0000_0000;

    typedef logic signed [2:0] t_weight;

    localparam t_weight MODE_WEIGHTS [4][5] = '{
        '{3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd1},
        '{3'sd2, -3'sd1, -3'sd1, 3'sd2, -3'sd1},
        '{3'sd2, -3'sd1, -3'sd1, 3'sd1, 3'sd0},
        '{3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0}
    };

    localparam int TERM_SRC [6][3] = '{
        '{0, 1, 3}, '{1, 0, 4}, '{2, 4, 5}, '{3, 5, 0}, '{4, 2, 1}, '{5, 3, 2}
    };

    localparam int OUT_PAIR [6][2] = '{
        '{0, 2}, '{1, 5}, '{2, 0}, '{3, 4}, '{4, 3}, '{5, 1}
    };

endpackage

### design/t3oss_mul.sv
// Two-stage signed multiplier built from four registered partial products.
`timescale 1ns / 1ps

module t3oss_mul #(
    parameter int A_W = t3oss_pkg::DEFAULT_VALUE_WIDTH,
    parameter int B_W = t3oss_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                        i_clk,
    input  logic signed [A_W-1:0]       i_a,
    input  logic signed [B_W-1:0]       i_b,
    output logic signed [A_W+B_W-1:0]   o_p
);

    localparam int LA = A_W / 2;
    localparam int HA = A_W - LA;
    localparam int LB = B_W / 2;
    localparam int HB = B_W - LB;
    localparam int PW = A_W + B_W;

    logic signed [LA:0]         a_lo;
    logic signed [HA-1:0]       a_hi;
    logic signed [LB:0]         b_lo;
    logic signed [HB-1:0]       b_hi;

    logic signed [LA+LB+1:0]    r_ll;
    logic signed [LA+HB:0]      r_lh;
    logic signed [HA+LB:0]      r_hl;
    logic signed [HA+HB-1:0]    r_hh;
    logic signed [PW-1:0]       r_p;
    logic signed [PW-1:0]       n_p;

    assign a_lo = $signed({1'b0, i_a[LA-1:0]});
    assign a_hi = $signed(i_a[A_W-1:LA]);
    assign b_lo = $signed({1'b0, i_b[LB-1:0]});
    assign b_hi = $signed(i_b[B_W-1:LB]);

    always_ff @(posedge i_clk) begin
        r_ll <= a_lo * b_lo;
        r_lh <= a_lo * b_hi;
        r_hl <= a_hi * b_lo;
        r_hh <= a_hi * b_hi;
        r_p  <= n_p;
    end

    always_comb begin
        n_p = PW'(r_ll)
            + (PW'(r_lh) <<< LB)
            + (PW'(r_hl) <<< LA)
            + (PW'(r_hh) <<< (LA + LB));
    end

    assign o_p = r_p;

endmodule

### design/t3_orbit_spin_summation.sv
// Top level of the T3 orbit spin summation block with its register port.
`timescale 1ns / 1ps

// One orbit of six tensor values is taken in every clock cycle; busy never rises. Each
// transaction gives one result, shown on the result ports with o_valid for a single cycle,
// in the order of acceptance. The pipeline has six register stages: the orbit terms, the
// symmetrized sum, the multipliers split into four registered partial products and their
// recombination, the final accumulate, and the rounding with saturation. o_valid is start
// carried along in r_vld; the result is taken at the edge after it rises. The receiver
// cannot stall, so results must be captured when o_valid is high. The user must write
// registers through the APB port only while no transaction is in flight; not enforced.
module t3_orbit_spin_summation #(
    parameter int VALUE_WIDTH = t3oss_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [VALUE_WIDTH-1:0]       i_v_abc,
    input  logic signed [VALUE_WIDTH-1:0]       i_v_cba,
    input  logic signed [VALUE_WIDTH-1:0]       i_v_acb,
    input  logic signed [VALUE_WIDTH-1:0]       i_v_bac,
    input  logic signed [VALUE_WIDTH-1:0]       i_v_bca,
    input  logic signed [VALUE_WIDTH-1:0]       i_v_cab,
    output logic                                o_valid,
    output logic signed [VALUE_WIDTH-1:0]       o_r_abc,
    output logic signed [VALUE_WIDTH-1:0]       o_r_cba,
    output logic signed [VALUE_WIDTH-1:0]       o_r_acb,
    output logic signed [VALUE_WIDTH-1:0]       o_r_bac,
    output logic signed [VALUE_WIDTH-1:0]       o_r_bca,
    output logic signed [VALUE_WIDTH-1:0]       o_r_cab,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [t3oss_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [t3oss_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [t3oss_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int W = VALUE_WIDTH;
    localparam int N = t3oss_pkg::NUM_MEMBERS;
    localparam int TW = W + 2;
    localparam int SW = W + 4;
    localparam int AW = 2 * W + 5;
    localparam int FB = t3oss_pkg::FRAC_BITS;
    localparam int DW = t3oss_pkg::APB_DATA_W;

    localparam logic signed [AW-1:0] RND = {{(AW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
    localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    typedef logic signed [W-1:0]  t_val;
    typedef logic signed [TW-1:0] t_term;
    typedef logic signed [SW-1:0] t_sym;
    typedef logic signed [AW-1:0] t_acc;

    logic [1:0]     r_mode;
    t_val           r_alpha;
    t_val           r_beta;
    logic           cfg_wr;
    logic [1:0]     cfg_idx;

    logic [5:0]     r_vld;
    t_val           in_v [N];
    t_val           r_v1 [N];
    t_val           r_v2 [N];
    t_val           r_v3 [N];
    t_val           r_v4 [N];
    t_val           r_v5 [N];
    t_term          r_t [N];
    t_term          n_t [N];
    t_sym           r_s [N];
    t_sym           n_s [N];
    logic signed [W+SW-1:0] pa [N];
    logic signed [2*W-1:0]  pb [N];
    t_acc           r_acc [N];
    t_val           r_out [N];
    t_val           n_out [N];

    function automatic t_sym f_scale(t_sym x, t3oss_pkg::t_weight w);
        t_sym res;
        case (w)
            3'sd1:   res = x;
            3'sd2:   res = x <<< 1;
            -3'sd1:  res = -x;
            default: res = '0;
        endcase
        return res;
    endfunction

    assign busy = 1'b0;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign cfg_idx = paddr[t3oss_pkg::APB_ADDR_W-1:t3oss_pkg::REG_IDX_LSB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= t3oss_pkg::MODE_FULL;
            r_alpha <= t3oss_pkg::ALPHA_RESET[W-1:0];
            r_beta  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                t3oss_pkg::REG_MODE:  r_mode  <= pwdata[1:0];
                t3oss_pkg::REG_ALPHA: r_alpha <= pwdata[W-1:0];
                t3oss_pkg::REG_BETA:  r_beta  <= pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            t3oss_pkg::REG_MODE:  prdata = DW'(r_mode);
            t3oss_pkg::REG_ALPHA: prdata = DW'(r_alpha);
            t3oss_pkg::REG_BETA:  prdata = DW'(r_beta);
            default:              prdata = '0;
        endcase
    end

    assign in_v[0] = i_v_abc;
    assign in_v[1] = i_v_cba;
    assign in_v[2] = i_v_acb;
    assign in_v[3] = i_v_bac;
    assign in_v[4] = i_v_bca;
    assign in_v[5] = i_v_cab;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_t[i] = TW'(f_scale(SW'(in_v[t3oss_pkg::TERM_SRC[i][0]]),
                                 t3oss_pkg::MODE_WEIGHTS[r_mode][0])
                       + f_scale(SW'(in_v[t3oss_pkg::TERM_SRC[i][1]]),
                                 t3oss_pkg::MODE_WEIGHTS[r_mode][1])
                       + f_scale(SW'(in_v[t3oss_pkg::TERM_SRC[i][2]]),
                                 t3oss_pkg::MODE_WEIGHTS[r_mode][2]));
            n_s[i] = f_scale(SW'(r_t[t3oss_pkg::OUT_PAIR[i][0]]),
                             t3oss_pkg::MODE_WEIGHTS[r_mode][3])
                   + f_scale(SW'(r_t[t3oss_pkg::OUT_PAIR[i][1]]),
                             t3oss_pkg::MODE_WEIGHTS[r_mode][4]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            r_v1[i]  <= in_v[i];
            r_t[i]   <= n_t[i];
            r_v2[i]  <= r_v1[i];
            r_s[i]   <= n_s[i];
            r_v3[i]  <= r_v2[i];
            r_v4[i]  <= r_v3[i];
            r_v5[i]  <= r_v4[i];
            r_acc[i] <= AW'(pa[i]) + AW'(pb[i]) + RND;
            r_out[i] <= n_out[i];
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_mul
        t3oss_mul #(
            .A_W (W),
            .B_W (SW)
        ) u_mul_alpha (
            .i_clk (i_clk),
            .i_a   (r_alpha),
            .i_b   (r_s[g]),
            .o_p   (pa[g])
        );

        t3oss_mul #(
            .A_W (W),
            .B_W (W)
        ) u_mul_beta (
            .i_clk (i_clk),
            .i_a   (r_beta),
            .i_b   (r_v2[g]),
            .o_p   (pb[g])
        );
    end

    always_comb begin
        t_acc sh;
        logic fits;
        for (int i = 0; i < N; i++) begin
            sh = r_acc[i] >>> FB;
            fits = (&sh[AW-1:W-1]) | ~(|sh[AW-1:W-1]);
            if (r_mode == t3oss_pkg::MODE_PASS) begin
                n_out[i] = r_v5[i];
            end else if (fits) begin
                n_out[i] = sh[W-1:0];
            end else if (sh[AW-1]) begin
                n_out[i] = SAT_MIN;
            end else begin
                n_out[i] = SAT_MAX;
            end
        end
    end

    assign o_valid = r_vld[5];
    assign o_r_abc = r_out[0];
    assign o_r_cba = r_out[1];
    assign o_r_acb = r_out[2];
    assign o_r_bac = r_out[3];
    assign o_r_bca = r_out[4];
    assign o_r_cab = r_out[5];

endmodule
